/* hdl/lbfv_pkg.sv */
// Shared types and widths for the four-vector boost pipeline.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package lbfv_pkg;

    localparam int unsigned WordW  = 32;  // Q16.16 components and Q2.30 velocities
    localparam int unsigned DotW   = 35;  // sum of three rounded p*B terms
    localparam int unsigned RadW   = 63;  // 4*(1 - beta^2) in Q.60, i.e. 1 - beta^2 in Q.62
    localparam int unsigned RootW  = 32;  // sqrt(1 - beta^2) in Q.31
    localparam int unsigned GNumW  = 64;  // numerator bits of the gamma divide
    localparam int unsigned GW     = 63;  // gamma, unsigned Q31.32
    localparam int unsigned QW     = 32;  // 1/(gamma+1), Q0.32

    // operands that ride along with an item through the root and divides
    typedef struct packed {
        logic signed [WordW-1:0] t;
        logic signed [WordW-1:0] px;
        logic signed [WordW-1:0] py;
        logic signed [WordW-1:0] pz;
        logic signed [WordW-1:0] bx;
        logic signed [WordW-1:0] by;
        logic signed [WordW-1:0] bz;
        logic signed [DotW-1:0]  dot;
        logic                    sup;
    } vec_t;

    localparam int unsigned VecW = $bits(vec_t);

    typedef struct packed {
        logic signed [WordW-1:0] energy;
        logic signed [WordW-1:0] mom_x;
        logic signed [WordW-1:0] mom_y;
        logic signed [WordW-1:0] mom_z;
        logic                    superluminal;
        logic                    saturated;
    } res_t;

endpackage

`default_nettype wire

/* hdl/lbfv_prep.sv */
// Front end: input register, squares and p*B products, beta^2, dot product.
// Uses lbfv_pkg. Four register stages, advanced by a common clock enable.
`default_nettype none

module lbfv_prep (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               ce,
    input  wire logic               in_valid,
    input  wire logic signed [31:0] energy_in,
    input  wire logic signed [31:0] mom_x_in,
    input  wire logic signed [31:0] mom_y_in,
    input  wire logic signed [31:0] mom_z_in,
    input  wire logic signed [31:0] beta_x,
    input  wire logic signed [31:0] beta_y,
    input  wire logic signed [31:0] beta_z,
    output logic                    out_valid,
    output logic [lbfv_pkg::RadW-1:0] rad,
    output lbfv_pkg::vec_t          vec
);
    import lbfv_pkg::*;

    // round(x / 2^30), ties away from zero
    function automatic logic signed [33:0] rnd30(input logic signed [63:0] x);
        logic signed [64:0] acc;
        acc = 65'(x) + (x[63] ? 65'sd536870911 : 65'sd536870912);
        return acc[63:30];
    endfunction

    logic [3:0]         vld_reg;
    vec_t               v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [63:0] sq_reg  [3];
    logic signed [63:0] prd_reg [3];
    logic [63:0]        b2_reg;
    logic signed [33:0] dt_reg  [3];
    logic [RadW-1:0]    rad_reg;

    logic               sup_c;
    logic [63:0]        d_c;
    vec_t               v3_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_comb begin
        sup_c    = |b2_reg[63:60];
        d_c      = 64'h1000_0000_0000_0000 - b2_reg;
        v3_c     = v2_reg;
        v3_c.dot = 35'(dt_reg[0]) + 35'(dt_reg[1]) + 35'(dt_reg[2]);
        v3_c.sup = sup_c;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v0_reg.t   <= energy_in;
            v0_reg.px  <= mom_x_in;
            v0_reg.py  <= mom_y_in;
            v0_reg.pz  <= mom_z_in;
            v0_reg.bx  <= beta_x;
            v0_reg.by  <= beta_y;
            v0_reg.bz  <= beta_z;
            v0_reg.dot <= '0;
            v0_reg.sup <= 1'b0;

            v1_reg     <= v0_reg;
            sq_reg[0]  <= v0_reg.bx * v0_reg.bx;
            sq_reg[1]  <= v0_reg.by * v0_reg.by;
            sq_reg[2]  <= v0_reg.bz * v0_reg.bz;
            prd_reg[0] <= v0_reg.px * v0_reg.bx;
            prd_reg[1] <= v0_reg.py * v0_reg.by;
            prd_reg[2] <= v0_reg.pz * v0_reg.bz;

            v2_reg    <= v1_reg;
            b2_reg    <= $unsigned(sq_reg[0]) + $unsigned(sq_reg[1]) + $unsigned(sq_reg[2]);
            dt_reg[0] <= rnd30(prd_reg[0]);
            dt_reg[1] <= rnd30(prd_reg[1]);
            dt_reg[2] <= rnd30(prd_reg[2]);

            v3_reg     <= v3_c;
            rad_reg    <= sup_c ? '0 : {d_c[60:0], 2'b00};
        end
    end

    assign out_valid = vld_reg[3];
    assign rad       = rad_reg;
    assign vec       = v3_reg;

endmodule

`default_nettype wire

/* hdl/lbfv_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Uses lbfv_pkg. Carries the item's operands alongside.
`default_nettype none

module lbfv_sqrt (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    ce,
    input  wire logic                    in_valid,
    input  wire logic [lbfv_pkg::RadW-1:0] rad,
    input  wire lbfv_pkg::vec_t          vec_in,
    output logic                         out_valid,
    output logic [lbfv_pkg::RootW-1:0]   root,
    output lbfv_pkg::vec_t               vec_out
);
    import lbfv_pkg::*;

    localparam int unsigned Steps = RootW;

    logic [Steps-1:0] vld_reg;
    logic [RadW-1:0]  rem_reg [Steps];
    logic [63:0]      res_reg [Steps];
    vec_t             vec_reg [Steps];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[Steps-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < Steps; k++) begin : g_step
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic [RadW-1:0] rem_i;
        logic [63:0]     res_i;
        logic [63:0]     trial;
        vec_t            vec_i;

        if (k == 0) begin : g_first
            assign rem_i = rad;
            assign res_i = '0;
            assign vec_i = vec_in;
        end else begin : g_next
            assign rem_i = rem_reg[k-1];
            assign res_i = res_reg[k-1];
            assign vec_i = vec_reg[k-1];
        end

        assign trial = res_i + Bit;

        always_ff @(posedge aclk) begin
            if (ce) begin
                vec_reg[k] <= vec_i;
                if ({1'b0, rem_i} >= trial) begin
                    rem_reg[k] <= rem_i - trial[RadW-1:0];
                    res_reg[k] <= (res_i >> 1) + Bit;
                end else begin
                    rem_reg[k] <= rem_i;
                    res_reg[k] <= res_i >> 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[Steps-1];
    assign root      = res_reg[Steps-1][RootW-1:0];
    assign vec_out   = vec_reg[Steps-1];

endmodule

`default_nettype wire

/* hdl/lbfv_udiv.sv */
// Pipelined restoring unsigned divider, one quotient bit per register stage.
// Uses lbfv_pkg for parameter defaults. Side bits travel with each transaction.
`default_nettype none

module lbfv_udiv #(
    parameter int unsigned STEPS = lbfv_pkg::GNumW,
    parameter int unsigned DW    = lbfv_pkg::RootW,
    parameter int unsigned CW    = lbfv_pkg::VecW
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             ce,
    input  wire logic             in_valid,
    input  wire logic [STEPS-1:0] num,
    input  wire logic [DW-1:0]    den,
    input  wire logic [DW-1:0]    rem0,
    input  wire logic [CW-1:0]    side_in,
    output logic                  out_valid,
    output logic [STEPS-1:0]      quot,
    output logic [CW-1:0]         side_out
);

    logic [STEPS-1:0] vld_reg;
    logic [DW-1:0]    rem_reg  [STEPS];
    logic [STEPS-1:0] nq_reg   [STEPS];  // numerator bits shift out, quotient bits in
    logic [DW-1:0]    den_reg  [STEPS];
    logic [CW-1:0]    side_reg [STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[STEPS-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [DW-1:0]    rem_i;
        logic [DW-1:0]    den_i;
        logic [STEPS-1:0] nq_i;
        logic [CW-1:0]    side_i;
        logic [DW:0]      shl;
        logic [DW+1:0]    diff;
        logic             qbit;

        if (k == 0) begin : g_first
            assign rem_i  = rem0;
            assign den_i  = den;
            assign nq_i   = num;
            assign side_i = side_in;
        end else begin : g_next
            assign rem_i  = rem_reg[k-1];
            assign den_i  = den_reg[k-1];
            assign nq_i   = nq_reg[k-1];
            assign side_i = side_reg[k-1];
        end

        assign shl  = {rem_i, nq_i[STEPS-1]};
        assign diff = {1'b0, shl} - {2'b00, den_i};
        assign qbit = ~diff[DW+1];

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= qbit ? diff[DW-1:0] : shl[DW-1:0];
                nq_reg[k]   <= {nq_i[STEPS-2:0], qbit};
                den_reg[k]  <= den_i;
                side_reg[k] <= side_i;
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign quot      = nq_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

`default_nettype wire

/* hdl/lbfv_apply.sv */
// Back end: applies gamma and 1/(gamma+1) to the four-vector, rounds, saturates.
// Uses lbfv_pkg. Eight register stages; wide products are split in 32-bit halves.
`default_nettype none

module lbfv_apply (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ce,
    input  wire logic                  in_valid,
    input  wire logic [lbfv_pkg::GW-1:0] gamma,
    input  wire logic [lbfv_pkg::QW-1:0] recip,
    input  wire lbfv_pkg::vec_t        vec_in,
    output logic                       out_valid,
    output lbfv_pkg::res_t             res
);
    import lbfv_pkg::*;

    localparam logic [67:0] MagLim = 68'h4000_0000_0000_0000;

    function automatic logic [32:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return {1'b1, 32'h7FFF_FFFF};
        end else if (v < -64'sd2147483648) begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    logic [7:0]         vld_reg;
    vec_t               v_reg [7];

    // stage 1
    logic [34:0]        ua_reg;
    logic               un_reg [2];
    logic [33:0]        da_reg;
    logic               dn_reg [2];
    logic [GW-1:0]      g1_reg;
    logic [QW-1:0]      q1_reg;
    // stage 2
    logic [66:0]        pl_reg;
    logic [65:0]        ph_reg;
    logic [65:0]        pc_reg;
    // stage 3
    logic signed [63:0] t3_reg;
    logic signed [35:0] c3_reg;
    // stage 4 onward
    logic signed [63:0] w_reg;
    logic [31:0]        et_reg [4];
    logic               ec_reg [4];
    logic [62:0]        wa_reg;
    logic [31:0]        ba_reg [3];
    logic               ng_reg [3];
    logic               ng6_reg [3];
    logic [63:0]        p1_reg [3];
    logic [62:0]        p2_reg [3];
    logic signed [63:0] m_reg  [3];
    res_t               res_reg;

    logic signed [35:0] u_c;
    logic signed [31:0] bv [3];
    logic signed [31:0] pv [3];
    logic [67:0]        mag_a_c;
    logic [63:0]        tm_c;
    logic [34:0]        mag_c_c;
    logic [65:0]        mag_c [3];
    logic [32:0]        es_c;
    logic [32:0]        ps_c [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[6:0], in_valid};
        end
    end

    always_comb begin
        u_c   = 36'(vec_in.t) - 36'(vec_in.dot);
        bv[0] = v_reg[3].bx;
        bv[1] = v_reg[3].by;
        bv[2] = v_reg[3].bz;
        pv[0] = v_reg[6].px;
        pv[1] = v_reg[6].py;
        pv[2] = v_reg[6].pz;

        mag_a_c = 68'(ph_reg) + ((68'(pl_reg) + 68'h8000_0000) >> 32);
        if (mag_a_c > MagLim) begin
            mag_a_c = MagLim;
        end
        tm_c    = mag_a_c[63:0];
        mag_c_c = 35'((67'(pc_reg) + 67'h8000_0000) >> 32);

        for (int i = 0; i < 3; i++) begin
            mag_c[i] = (66'(p2_reg[i]) << 2) + 66'((65'(p1_reg[i]) + 65'h2000_0000) >> 30);
            if (mag_c[i] > 66'(MagLim)) begin
                mag_c[i] = 66'(MagLim);
            end
        end

        es_c = sat32(t3_reg);
        for (int i = 0; i < 3; i++) begin
            ps_c[i] = sat32(64'(pv[i]) + m_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg[0] <= vec_in;
            for (int i = 1; i < 7; i++) begin
                v_reg[i] <= v_reg[i-1];
            end

            // stage 1: magnitudes of t - D and D
            ua_reg    <= u_c[35] ? 35'(-u_c) : u_c[34:0];
            un_reg[0] <= u_c[35];
            da_reg    <= vec_in.dot[34] ? 34'(-vec_in.dot) : vec_in.dot[33:0];
            dn_reg[0] <= vec_in.dot[34];
            g1_reg    <= gamma;
            q1_reg    <= recip;

            // stage 2: partial products
            pl_reg    <= ua_reg * g1_reg[31:0];
            ph_reg    <= ua_reg * g1_reg[62:32];
            pc_reg    <= da_reg * q1_reg;
            un_reg[1] <= un_reg[0];
            dn_reg[1] <= dn_reg[0];

            // stage 3: round to Q16.16, gamma*(t - D) and D/(gamma+1)
            t3_reg <= un_reg[1] ? -$signed(tm_c) : $signed(tm_c);
            c3_reg <= dn_reg[1] ? -$signed({1'b0, mag_c_c}) : $signed({1'b0, mag_c_c});

            // stage 4: w = gamma*(D - t) - D + D/(gamma+1)
            w_reg     <= -t3_reg - 64'(v_reg[2].dot) + 64'(c3_reg);
            et_reg[0] <= es_c[31:0];
            ec_reg[0] <= es_c[32];

            // stage 5: magnitudes for w*B
            wa_reg <= w_reg[63] ? 63'(-w_reg) : w_reg[62:0];
            for (int i = 0; i < 3; i++) begin
                ba_reg[i] <= bv[i][31] ? 32'(-bv[i]) : bv[i];
                ng_reg[i] <= w_reg[63] ^ bv[i][31];
            end

            // stage 6: split products
            for (int i = 0; i < 3; i++) begin
                p1_reg[i]  <= wa_reg[31:0] * ba_reg[i];
                p2_reg[i]  <= wa_reg[62:32] * ba_reg[i];
                ng6_reg[i] <= ng_reg[i];
            end

            // stage 7: rounded, clipped w*B_i
            for (int i = 0; i < 3; i++) begin
                m_reg[i] <= ng6_reg[i] ? -$signed(mag_c[i][63:0]) : $signed(mag_c[i][63:0]);
            end

            for (int i = 1; i < 4; i++) begin
                et_reg[i] <= et_reg[i-1];
                ec_reg[i] <= ec_reg[i-1];
            end

            // stage 8: p_i + w*B_i, saturate; superluminal forces zeros
            if (v_reg[6].sup) begin
                res_reg.energy       <= '0;
                res_reg.mom_x        <= '0;
                res_reg.mom_y        <= '0;
                res_reg.mom_z        <= '0;
                res_reg.superluminal <= 1'b1;
                res_reg.saturated    <= 1'b0;
            end else begin
                res_reg.energy       <= et_reg[3];
                res_reg.mom_x        <= ps_c[0][31:0];
                res_reg.mom_y        <= ps_c[1][31:0];
                res_reg.mom_z        <= ps_c[2][31:0];
                res_reg.superluminal <= 1'b0;
                res_reg.saturated    <= ec_reg[3] | ps_c[0][32] | ps_c[1][32] | ps_c[2][32];
            end
        end
    end

    assign out_valid = vld_reg[7];
    assign res       = res_reg;

endmodule

`default_nettype wire

/* hdl/lorentz_boost_four_vector_top.sv */
// General Lorentz boost of a Q16.16 four-vector by a Q2.30 velocity.
// Uses lbfv_pkg, lbfv_prep, lbfv_sqrt, lbfv_udiv and lbfv_apply.
//
// Usage:
//   Input channel s_*: one transaction carries the four-vector and the
//   velocity. Output channel m_*: one transaction per input, in order,
//   with the boosted vector and the superluminal / saturated flags.
//   Both channels use valid/ready.
// Throughput: one transaction per clock while the pipeline is not frozen
//   (see Stall below). Every stage is a register with a common clock enable;
//   the square root and the two divides retire one quotient or root bit per stage.
// Depth: the path has 141 register stages: 4 front-end, the 32-stage
//   root, the 64-stage gamma divide, the 32-stage 1/(gamma+1) divide,
//   8 back-end and 1 output stage.
// Reset: aresetn (synchronous, active low) clears all valid bits; the
//   pipeline comes up empty, s_ready is low during reset and high after.
// Stall: the output register has a one-entry skid buffer. When m_ready is
//   low and the skid fills, the whole pipeline freezes and s_ready drops;
//   nothing is lost or repeated.
`default_nettype none

module lorentz_boost_four_vector_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_energy_in,
    input  wire logic signed [31:0] s_mom_x_in,
    input  wire logic signed [31:0] s_mom_y_in,
    input  wire logic signed [31:0] s_mom_z_in,
    input  wire logic signed [31:0] s_beta_x,
    input  wire logic signed [31:0] s_beta_y,
    input  wire logic signed [31:0] s_beta_z,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_energy_out,
    output logic signed [31:0]      m_mom_x_out,
    output logic signed [31:0]      m_mom_y_out,
    output logic signed [31:0]      m_mom_z_out,
    output logic                    m_superluminal,
    output logic                    m_saturated
);
    import lbfv_pkg::*;

    logic            ce;
    logic            pr_valid, sq_valid, gd_valid, qd_valid, ap_valid;
    logic [RadW-1:0] pr_rad;
    vec_t            pr_vec, sq_vec, gd_vec, qd_vec;
    logic [RootW-1:0] sq_root;
    logic [GNumW-1:0] gd_quot;
    logic [VecW-1:0]  gd_side;
    logic [GW-1:0]    gam;
    logic [GW-1:0]    hden;
    logic [QW-1:0]    qd_quot;
    logic [GW+VecW-1:0] qd_side_in, qd_side;
    logic [GW-1:0]    qd_gam;
    res_t             ap_res;

    logic   m_valid_reg, m_valid_next;
    logic   skid_full_reg, skid_full_next;
    res_t   main_reg, skid_reg;
    logic   pop, push, load_main, load_skid, main_from_skid;

    assign ce      = ~skid_full_reg;
    assign s_ready = ce & aresetn;

    lbfv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid & s_ready),
        .energy_in (s_energy_in),
        .mom_x_in  (s_mom_x_in),
        .mom_y_in  (s_mom_y_in),
        .mom_z_in  (s_mom_z_in),
        .beta_x    (s_beta_x),
        .beta_y    (s_beta_y),
        .beta_z    (s_beta_z),
        .out_valid (pr_valid),
        .rad       (pr_rad),
        .vec       (pr_vec)
    );

    lbfv_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (pr_valid),
        .rad       (pr_rad),
        .vec_in    (pr_vec),
        .out_valid (sq_valid),
        .root      (sq_root),
        .vec_out   (sq_vec)
    );

    // gamma = round(2^63 / s)
    lbfv_udiv #(
        .STEPS (GNumW),
        .DW    (RootW),
        .CW    (VecW)
    ) u_gdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sq_valid),
        .num       ({1'b1, 32'd0, sq_root[RootW-1:1]}),
        .den       (sq_root),
        .rem0      ('0),
        .side_in   (sq_vec),
        .out_valid (gd_valid),
        .quot      (gd_quot),
        .side_out  (gd_side)
    );

    assign gd_vec     = vec_t'(gd_side);
    assign gam        = gd_quot[GW-1:0];
    assign hden       = gam + 63'h1_0000_0000;
    assign qd_side_in = {gam, gd_vec};

    // 1/(gamma+1) = floor(2^64 / h); the upper half of 2^64 seeds the remainder
    lbfv_udiv #(
        .STEPS (QW),
        .DW    (GW),
        .CW    (GW + VecW)
    ) u_qdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (gd_valid),
        .num       ('0),
        .den       (hden),
        .rem0      (63'h1_0000_0000),
        .side_in   (qd_side_in),
        .out_valid (qd_valid),
        .quot      (qd_quot),
        .side_out  (qd_side)
    );

    assign qd_gam = qd_side[GW+VecW-1:VecW];
    assign qd_vec = vec_t'(qd_side[VecW-1:0]);

    lbfv_apply u_apply (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (qd_valid),
        .gamma     (qd_gam),
        .recip     (qd_quot),
        .vec_in    (qd_vec),
        .out_valid (ap_valid),
        .res       (ap_res)
    );

    // output register plus one-entry skid
    always_comb begin
        pop            = m_valid_reg & m_ready;
        push           = ce & ap_valid;
        m_valid_next   = m_valid_reg;
        skid_full_next = skid_full_reg;
        load_main      = 1'b0;
        load_skid      = 1'b0;
        main_from_skid = 1'b0;
        if (skid_full_reg) begin
            if (pop) begin
                main_from_skid = 1'b1;
                skid_full_next = 1'b0;
            end
        end else if (push) begin
            if (!m_valid_reg || pop) begin
                load_main    = 1'b1;
                m_valid_next = 1'b1;
            end else begin
                load_skid      = 1'b1;
                skid_full_next = 1'b1;
            end
        end else if (pop) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (main_from_skid) begin
            main_reg <= skid_reg;
        end else if (load_main) begin
            main_reg <= ap_res;
        end
        if (load_skid) begin
            skid_reg <= ap_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_energy_out   = main_reg.energy;
    assign m_mom_x_out    = main_reg.mom_x;
    assign m_mom_y_out    = main_reg.mom_y;
    assign m_mom_z_out    = main_reg.mom_z;
    assign m_superluminal = main_reg.superluminal;
    assign m_saturated    = main_reg.saturated;

    a_skid_needs_main: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid holds a transaction while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid filled without an output stall");

    a_superluminal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_superluminal) |-> (m_energy_out == 0 && m_mom_x_out == 0 &&
            m_mom_y_out == 0 && m_mom_z_out == 0 && !m_saturated))
        else $error("superluminal result with nonzero components or saturation flag");

    a_frozen_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |=> ($stable(skid_reg) || $past(pop)))
        else $error("skid contents changed while full and not drained");

endmodule

`default_nettype wire
